// ===== rtl/core/arc_pkg.sv =====
// ----------------------------------------------------------------------------
// arc_pkg
// Shared constants, codes and controller/datapath interface types for the
// address resolution cache.
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

  // sizing
  localparam int ENTRIES     = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int QPOS_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W      = QCNT_W + 1;
  localparam int HMEM_DEPTH  = ENTRIES * QUEUE_DEPTH;
  localparam int HADDR_W     = $clog2(HMEM_DEPTH);

  // field widths
  localparam int ACT_W  = 3;
  localparam int NET_W  = 32;
  localparam int MAC_W  = 48;
  localparam int ADDR_W = 32;
  localparam int HDL_W  = 8;
  localparam int KIND_W = 3;
  localparam int STS_W  = 2;
  localparam int FLG_W  = 3;
  localparam int CNT_W  = 4;
  localparam int TMR_W  = 16;
  localparam int CFGI_W = 8;
  localparam int CFGD_W = 16;

  // entry status codes
  localparam logic [STS_W-1:0] STS_INCOMPLETE = 2'd0;
  localparam logic [STS_W-1:0] STS_REACHABLE  = 2'd1;
  localparam logic [STS_W-1:0] STS_FAILED     = 2'd2;

  // probe flag bits
  localparam int FLAG_PROBING = 0;
  localparam int FLAG_LOCAL   = 1;
  localparam int FLAG_REMOTE  = 2;

  // actions
  localparam logic [ACT_W-1:0] ACT_RESOLVE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ANNOUNCE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TICK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SWEEP    = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DONE      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ANNOUNCE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SOL_LOCAL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SOL_REM   = 3'd5;

  // configuration register indexes and reset values
  localparam logic [CFGI_W-1:0] CFG_PROBE_LIMIT = 8'd0;
  localparam logic [CFGI_W-1:0] CFG_LOCAL_DELAY = 8'd1;
  localparam logic [CFGI_W-1:0] CFG_ENTRY_TTL   = 8'd2;
  localparam logic [CFGI_W-1:0] CFG_QUEUE_LIMIT = 8'd3;
  localparam logic [CNT_W-1:0]  RST_PROBE_LIMIT = 4'd3;
  localparam logic [TMR_W-1:0]  RST_LOCAL_DELAY = 16'd100;
  localparam logic [TMR_W-1:0]  RST_ENTRY_TTL   = 16'd1000;
  localparam logic [CNT_W-1:0]  RST_QUEUE_LIMIT = 4'd8;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LATCH     = 4'd1;
  localparam logic [3:0] OP_SCAN      = 4'd2;
  localparam logic [3:0] OP_PICK      = 4'd3;
  localparam logic [3:0] OP_ALLOC     = 4'd4;
  localparam logic [3:0] OP_RESOLVE   = 4'd5;
  localparam logic [3:0] OP_ANN_SET   = 4'd6;
  localparam logic [3:0] OP_ANN_RD    = 4'd7;
  localparam logic [3:0] OP_REMOVE    = 4'd8;
  localparam logic [3:0] OP_TICK_ENT  = 4'd9;
  localparam logic [3:0] OP_NEXT      = 4'd10;
  localparam logic [3:0] OP_TICK_END  = 4'd11;
  localparam logic [3:0] OP_SWEEP_ALL = 4'd12;

  // result emission codes
  localparam logic [3:0] EM_NONE      = 4'd0;
  localparam logic [3:0] EM_FULL      = 4'd1;
  localparam logic [3:0] EM_NF        = 4'd2;
  localparam logic [3:0] EM_RES_DONE  = 4'd3;
  localparam logic [3:0] EM_ANN       = 4'd4;
  localparam logic [3:0] EM_ANN_DONE  = 4'd5;
  localparam logic [3:0] EM_REM_DONE  = 4'd6;
  localparam logic [3:0] EM_SOL_L     = 4'd7;
  localparam logic [3:0] EM_SOL_R     = 4'd8;
  localparam logic [3:0] EM_ZERO_DONE = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] em;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             hit;
    logic             free;
    logic             idx_last;
    logic             pend_loc;
    logic             pend_rem;
    logic             ann_zero;
    logic             can_emit;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/arc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arc_ctrl
// Sequencer: steps each action through lookup or walk, update and result.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire arc_pkg::status_t st,
  output arc_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_HIT      = 4'd3;
  localparam logic [3:0] S_ALLOC    = 4'd4;
  localparam logic [3:0] S_RES      = 4'd5;
  localparam logic [3:0] S_FULL     = 4'd6;
  localparam logic [3:0] S_NF       = 4'd7;
  localparam logic [3:0] S_ANN_SET  = 4'd8;
  localparam logic [3:0] S_ANN      = 4'd9;
  localparam logic [3:0] S_ANN_EM   = 4'd10;
  localparam logic [3:0] S_ANN_DONE = 4'd11;
  localparam logic [3:0] S_REM      = 4'd12;
  localparam logic [3:0] S_T_ENT    = 4'd13;
  localparam logic [3:0] S_T_SOL    = 4'd14;
  localparam logic [3:0] S_ZDONE    = 4'd15;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = arc_pkg::OP_NONE;
    cmd.em    = arc_pkg::EM_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = arc_pkg::OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.action)
          arc_pkg::ACT_RESOLVE, arc_pkg::ACT_ANNOUNCE, arc_pkg::ACT_REMOVE:
            state_nxt = S_SCAN;
          arc_pkg::ACT_TICK: state_nxt = S_T_ENT;
          arc_pkg::ACT_SWEEP: begin
            cmd.op    = arc_pkg::OP_SWEEP_ALL;
            state_nxt = S_ZDONE;
          end
          default: state_nxt = S_ZDONE;
        endcase
      end
      S_SCAN: begin
        cmd.op = arc_pkg::OP_SCAN;
        if (st.idx_last) state_nxt = S_HIT;
      end
      S_HIT: begin
        cmd.op = arc_pkg::OP_PICK;
        case (st.action)
          arc_pkg::ACT_RESOLVE:
            state_nxt = st.hit ? S_RES : (st.free ? S_ALLOC : S_FULL);
          arc_pkg::ACT_ANNOUNCE: state_nxt = st.hit ? S_ANN_SET : S_NF;
          arc_pkg::ACT_REMOVE:   state_nxt = st.hit ? S_REM : S_NF;
          default:               state_nxt = S_ZDONE;
        endcase
      end
      S_ALLOC: begin
        cmd.op    = arc_pkg::OP_ALLOC;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (st.can_emit) begin
          cmd.op    = arc_pkg::OP_RESOLVE;
          cmd.em    = arc_pkg::EM_RES_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_FULL: begin
        if (st.can_emit) begin
          cmd.em    = arc_pkg::EM_FULL;
          state_nxt = S_IDLE;
        end
      end
      S_NF: begin
        if (st.can_emit) begin
          cmd.em    = arc_pkg::EM_NF;
          state_nxt = S_IDLE;
        end
      end
      S_ANN_SET: begin
        cmd.op    = arc_pkg::OP_ANN_SET;
        state_nxt = S_ANN;
      end
      S_ANN: begin
        if (st.ann_zero) begin
          state_nxt = S_ANN_DONE;
        end else begin
          cmd.op    = arc_pkg::OP_ANN_RD;
          state_nxt = S_ANN_EM;
        end
      end
      S_ANN_EM: begin
        if (st.can_emit) begin
          cmd.em    = arc_pkg::EM_ANN;
          state_nxt = S_ANN;
        end
      end
      S_ANN_DONE: begin
        if (st.can_emit) begin
          cmd.em    = arc_pkg::EM_ANN_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_REM: begin
        if (st.can_emit) begin
          cmd.op    = arc_pkg::OP_REMOVE;
          cmd.em    = arc_pkg::EM_REM_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_T_ENT: begin
        cmd.op    = arc_pkg::OP_TICK_ENT;
        state_nxt = S_T_SOL;
      end
      S_T_SOL: begin
        if (st.pend_loc) begin
          if (st.can_emit) cmd.em = arc_pkg::EM_SOL_L;
        end else if (st.pend_rem) begin
          if (st.can_emit) cmd.em = arc_pkg::EM_SOL_R;
        end else if (st.idx_last) begin
          cmd.op    = arc_pkg::OP_TICK_END;
          state_nxt = S_ZDONE;
        end else begin
          cmd.op    = arc_pkg::OP_NEXT;
          state_nxt = S_T_ENT;
        end
      end
      S_ZDONE: begin
        if (st.can_emit) begin
          cmd.em    = arc_pkg::EM_ZERO_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/arc_dp.sv =====
// ----------------------------------------------------------------------------
// arc_dp
// Datapath: configuration, entry table, handle queue memory and the result
// register, driven by sequencer commands; configuration has its own write port.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire arc_pkg::cmd_t                 cmd,
  output arc_pkg::status_t                   st,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [arc_pkg::CFGI_W-1:0]    cfg_idx,
  input  wire logic [arc_pkg::CFGD_W-1:0]    cfg_wdata,
  // input item
  input  wire logic [arc_pkg::ACT_W-1:0]     in_action,
  input  wire logic [arc_pkg::NET_W-1:0]     in_net,
  input  wire logic [arc_pkg::MAC_W-1:0]     in_mac,
  input  wire logic [arc_pkg::ADDR_W-1:0]    in_addr,
  input  wire logic [arc_pkg::HDL_W-1:0]     in_hdl,
  input  wire logic                          in_loc,
  input  wire logic                          in_rem,
  // result register
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [arc_pkg::KIND_W-1:0]         out_kind,
  output logic [arc_pkg::NET_W-1:0]          out_net,
  output logic [arc_pkg::MAC_W-1:0]          out_mac,
  output logic [arc_pkg::ADDR_W-1:0]         out_addr,
  output logic [arc_pkg::HDL_W-1:0]          out_hdl,
  output logic                               out_last
);

  localparam int E  = arc_pkg::ENTRIES;
  localparam int QD = arc_pkg::QUEUE_DEPTH;
  localparam int IW = arc_pkg::IDX_W;
  localparam int PW = arc_pkg::QPOS_W;
  localparam int CW = arc_pkg::QCNT_W;
  localparam int SW = arc_pkg::QSUM_W;
  localparam int AW = arc_pkg::HADDR_W;

  // configuration registers
  logic [arc_pkg::CNT_W-1:0] probe_limit_r, queue_limit_r;
  logic [arc_pkg::TMR_W-1:0] local_delay_r, entry_ttl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_limit_r <= arc_pkg::RST_PROBE_LIMIT;
      local_delay_r <= arc_pkg::RST_LOCAL_DELAY;
      entry_ttl_r   <= arc_pkg::RST_ENTRY_TTL;
      queue_limit_r <= arc_pkg::RST_QUEUE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_idx)
        arc_pkg::CFG_PROBE_LIMIT: probe_limit_r <= cfg_wdata[arc_pkg::CNT_W-1:0];
        arc_pkg::CFG_LOCAL_DELAY: local_delay_r <= cfg_wdata;
        arc_pkg::CFG_ENTRY_TTL:   entry_ttl_r   <= cfg_wdata;
        arc_pkg::CFG_QUEUE_LIMIT: queue_limit_r <= cfg_wdata[arc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective timings and queue limit
  logic [arc_pkg::TMR_W-1:0] delay_eff, ttl_eff;
  logic [CW-1:0]             lim_eff;
  logic [7:0]                ql_wide;

  assign delay_eff = (local_delay_r == '0) ? arc_pkg::TMR_W'(1) : local_delay_r;
  assign ttl_eff   = (entry_ttl_r == '0) ? arc_pkg::TMR_W'(1) : entry_ttl_r;
  assign ql_wide   = 8'(queue_limit_r);

  always_comb begin
    if (ql_wide == 8'd0)             lim_eff = CW'(1);
    else if (ql_wide > 8'(QD))       lim_eff = CW'(QD);
    else                             lim_eff = CW'(ql_wide);
  end

  // latched input item
  logic [arc_pkg::ACT_W-1:0]  act_r;
  logic [arc_pkg::NET_W-1:0]  net_r;
  logic [arc_pkg::MAC_W-1:0]  mac_r;
  logic [arc_pkg::ADDR_W-1:0] addr_r;
  logic [arc_pkg::HDL_W-1:0]  hdl_r;
  logic                       want_loc_r, want_rem_r;

  always_ff @(posedge clk) begin
    if (cmd.op == arc_pkg::OP_LATCH) begin
      act_r      <= in_action;
      net_r      <= in_net;
      mac_r      <= in_mac;
      addr_r     <= in_addr;
      hdl_r      <= in_hdl;
      want_loc_r <= in_loc;
      want_rem_r <= in_rem;
    end
  end

  // entry table
  logic [arc_pkg::NET_W-1:0]  key_net_r [E];
  logic [arc_pkg::MAC_W-1:0]  key_mac_r [E];
  logic                       valid_r   [E];
  logic [arc_pkg::STS_W-1:0]  status_r  [E];
  logic [arc_pkg::FLG_W-1:0]  flags_r   [E];
  logic [arc_pkg::CNT_W-1:0]  pcount_r  [E];
  logic [arc_pkg::TMR_W-1:0]  ptimer_r  [E];
  logic [arc_pkg::TMR_W-1:0]  age_r     [E];
  logic [arc_pkg::ADDR_W-1:0] saddr_r   [E];
  logic [CW-1:0]              qcnt_r    [E];
  logic [PW-1:0]              qhead_r   [E];
  logic [arc_pkg::TMR_W-1:0]  sweep_r;

  // scan and selection state
  logic [IW-1:0] idx_r;
  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic          pend_loc_r, pend_rem_r;
  logic [CW-1:0] ann_n_r;
  logic          idx_last;

  assign idx_last = (idx_r == IW'(E - 1));

  // current entry
  logic                       cur_valid;
  logic [arc_pkg::FLG_W-1:0]  cur_flags;
  logic [arc_pkg::TMR_W-1:0]  cur_timer;
  logic [CW-1:0]              cur_cnt;
  logic [PW-1:0]              cur_head;
  logic                       cur_match;

  assign cur_valid = valid_r[idx_r];
  assign cur_flags = flags_r[idx_r];
  assign cur_timer = ptimer_r[idx_r];
  assign cur_cnt   = qcnt_r[idx_r];
  assign cur_head  = qhead_r[idx_r];
  assign cur_match = cur_valid && (key_net_r[idx_r] == net_r) && (key_mac_r[idx_r] == mac_r);

  // enqueue position: drop oldest until one place is free
  logic [SW-1:0] hsum, wsum, rsum;
  logic [PW-1:0] head_new, wpos, rpos;
  logic [CW-1:0] cnt_keep;
  logic [AW-1:0] waddr, raddr;

  always_comb begin
    if (cur_cnt >= lim_eff) begin
      hsum     = SW'(cur_head) + SW'(cur_cnt) - SW'(lim_eff) + SW'(1);
      cnt_keep = lim_eff - CW'(1);
    end else begin
      hsum     = SW'(cur_head);
      cnt_keep = cur_cnt;
    end
    head_new = (hsum >= SW'(QD)) ? PW'(hsum - SW'(QD)) : PW'(hsum);
    wsum     = SW'(head_new) + SW'(cnt_keep);
    wpos     = (wsum >= SW'(QD)) ? PW'(wsum - SW'(QD)) : PW'(wsum);
    rsum     = SW'(cur_head) + SW'(ann_n_r) - SW'(1);
    rpos     = (rsum >= SW'(QD)) ? PW'(rsum - SW'(QD)) : PW'(rsum);
    waddr    = AW'(idx_r) * AW'(QD) + AW'(wpos);
    raddr    = AW'(idx_r) * AW'(QD) + AW'(rpos);
  end

  // handle queue memory
  logic [arc_pkg::HDL_W-1:0] hmem [arc_pkg::HMEM_DEPTH];
  logic [arc_pkg::HDL_W-1:0] hrd_r;

  always_ff @(posedge clk) begin
    if (cmd.op == arc_pkg::OP_RESOLVE) hmem[waddr] <= hdl_r;
    if (cmd.op == arc_pkg::OP_ANN_RD)  hrd_r <= hmem[raddr];
  end

  // key store, written on allocation
  always_ff @(posedge clk) begin
    if (cmd.op == arc_pkg::OP_ALLOC) begin
      key_net_r[idx_r] <= net_r;
      key_mac_r[idx_r] <= mac_r;
    end
  end

  // expiry decision for the current entry
  logic expire_now, below_limit;

  assign expire_now  = cur_valid && (cur_timer == arc_pkg::TMR_W'(1));
  assign below_limit = (pcount_r[idx_r] < probe_limit_r);

  // scan, index and sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      hit_idx_r  <= '0;
      free_idx_r <= '0;
      pend_loc_r <= 1'b0;
      pend_rem_r <= 1'b0;
      ann_n_r    <= '0;
    end else begin
      case (cmd.op)
        arc_pkg::OP_LATCH: begin
          idx_r  <= '0;
          hit_r  <= 1'b0;
          free_r <= 1'b0;
        end
        arc_pkg::OP_SCAN: begin
          idx_r <= idx_last ? '0 : idx_r + IW'(1);
          if (cur_match && !hit_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= idx_r;
          end
          if (!cur_valid && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= idx_r;
          end
        end
        arc_pkg::OP_PICK:   idx_r <= hit_r ? hit_idx_r : free_idx_r;
        arc_pkg::OP_NEXT:   idx_r <= idx_r + IW'(1);
        arc_pkg::OP_ANN_SET: ann_n_r <= cur_cnt;
        arc_pkg::OP_ANN_RD:  ann_n_r <= ann_n_r - CW'(1);
        arc_pkg::OP_TICK_ENT: begin
          if (expire_now && status_r[idx_r] != arc_pkg::STS_REACHABLE
              && below_limit) begin
            pend_loc_r <= cur_flags[arc_pkg::FLAG_LOCAL];
            pend_rem_r <= cur_flags[arc_pkg::FLAG_REMOTE];
          end
        end
        default: ;
      endcase
      if (cmd.em == arc_pkg::EM_SOL_L) pend_loc_r <= 1'b0;
      if (cmd.em == arc_pkg::EM_SOL_R) pend_rem_r <= 1'b0;
    end
  end

  // entry state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < E; i++) begin
        valid_r[i]  <= 1'b0;
        status_r[i] <= arc_pkg::STS_INCOMPLETE;
        flags_r[i]  <= '0;
        pcount_r[i] <= '0;
        ptimer_r[i] <= '0;
        age_r[i]    <= '0;
        saddr_r[i]  <= '0;
        qcnt_r[i]   <= '0;
        qhead_r[i]  <= '0;
      end
      sweep_r <= '0;
    end else begin
      case (cmd.op)
        arc_pkg::OP_ALLOC: begin
          valid_r[idx_r]  <= 1'b1;
          status_r[idx_r] <= arc_pkg::STS_INCOMPLETE;
          flags_r[idx_r]  <= '0;
          pcount_r[idx_r] <= '0;
          ptimer_r[idx_r] <= '0;
          age_r[idx_r]    <= '0;
          saddr_r[idx_r]  <= '0;
          qcnt_r[idx_r]   <= '0;
        end
        arc_pkg::OP_RESOLVE: begin
          status_r[idx_r] <= arc_pkg::STS_INCOMPLETE;
          flags_r[idx_r]  <= cur_flags | {want_rem_r, want_loc_r, 1'b1};
          qcnt_r[idx_r]   <= cnt_keep + CW'(1);
          qhead_r[idx_r]  <= head_new;
          if (!cur_flags[arc_pkg::FLAG_PROBING]) begin
            pcount_r[idx_r] <= arc_pkg::CNT_W'(1);
            ptimer_r[idx_r] <= delay_eff;
          end
        end
        arc_pkg::OP_ANN_SET: begin
          saddr_r[idx_r]  <= addr_r;
          age_r[idx_r]    <= '0;
          status_r[idx_r] <= arc_pkg::STS_REACHABLE;
          qcnt_r[idx_r]   <= '0;
        end
        arc_pkg::OP_REMOVE: begin
          valid_r[idx_r]  <= 1'b0;
          status_r[idx_r] <= arc_pkg::STS_INCOMPLETE;
          flags_r[idx_r]  <= '0;
          pcount_r[idx_r] <= '0;
          ptimer_r[idx_r] <= '0;
          age_r[idx_r]    <= '0;
          saddr_r[idx_r]  <= '0;
          qcnt_r[idx_r]   <= '0;
        end
        arc_pkg::OP_TICK_ENT: begin
          if (cur_valid) begin
            if (age_r[idx_r] != '1) age_r[idx_r] <= age_r[idx_r] + arc_pkg::TMR_W'(1);
            if (cur_timer != '0) ptimer_r[idx_r] <= cur_timer - arc_pkg::TMR_W'(1);
          end
          if (expire_now) begin
            flags_r[idx_r] <= '0;
            if (status_r[idx_r] != arc_pkg::STS_REACHABLE) begin
              if (below_limit) begin
                if (pcount_r[idx_r] != '1)
                  pcount_r[idx_r] <= pcount_r[idx_r] + arc_pkg::CNT_W'(1);
              end else begin
                status_r[idx_r] <= arc_pkg::STS_FAILED;
                qcnt_r[idx_r]   <= '0;
              end
            end
          end
        end
        arc_pkg::OP_TICK_END: begin
          if (sweep_r + arc_pkg::TMR_W'(1) >= ttl_eff) begin
            sweep_r <= '0;
            for (int i = 0; i < E; i++) begin
              if (valid_r[i] && age_r[i] > ttl_eff)
                status_r[i] <= arc_pkg::STS_INCOMPLETE;
            end
          end else begin
            sweep_r <= sweep_r + arc_pkg::TMR_W'(1);
          end
        end
        arc_pkg::OP_SWEEP_ALL: begin
          for (int i = 0; i < E; i++) begin
            if (valid_r[i]) status_r[i] <= arc_pkg::STS_INCOMPLETE;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  logic                       out_valid_r;
  logic [arc_pkg::KIND_W-1:0] kind_r;
  logic [arc_pkg::NET_W-1:0]  onet_r;
  logic [arc_pkg::MAC_W-1:0]  omac_r;
  logic [arc_pkg::ADDR_W-1:0] oaddr_r;
  logic [arc_pkg::HDL_W-1:0]  ohdl_r;
  logic                       olast_r;

  logic [arc_pkg::KIND_W-1:0] kind_nxt;
  logic [arc_pkg::NET_W-1:0]  onet_nxt;
  logic [arc_pkg::MAC_W-1:0]  omac_nxt;
  logic [arc_pkg::ADDR_W-1:0] oaddr_nxt;
  logic [arc_pkg::HDL_W-1:0]  ohdl_nxt;
  logic                       olast_nxt;

  always_comb begin
    kind_nxt  = arc_pkg::KIND_DONE;
    onet_nxt  = net_r;
    omac_nxt  = mac_r;
    oaddr_nxt = '0;
    ohdl_nxt  = '0;
    olast_nxt = 1'b1;
    case (cmd.em)
      arc_pkg::EM_FULL: kind_nxt = arc_pkg::KIND_FULL;
      arc_pkg::EM_NF:   kind_nxt = arc_pkg::KIND_NOT_FOUND;
      arc_pkg::EM_RES_DONE, arc_pkg::EM_REM_DONE: oaddr_nxt = saddr_r[idx_r];
      arc_pkg::EM_ANN: begin
        kind_nxt  = arc_pkg::KIND_ANNOUNCE;
        oaddr_nxt = addr_r;
        ohdl_nxt  = hrd_r;
        olast_nxt = 1'b0;
      end
      arc_pkg::EM_ANN_DONE: oaddr_nxt = addr_r;
      arc_pkg::EM_SOL_L, arc_pkg::EM_SOL_R: begin
        kind_nxt  = (cmd.em == arc_pkg::EM_SOL_L) ? arc_pkg::KIND_SOL_LOCAL
                                                  : arc_pkg::KIND_SOL_REM;
        onet_nxt  = key_net_r[idx_r];
        omac_nxt  = key_mac_r[idx_r];
        oaddr_nxt = saddr_r[idx_r];
        olast_nxt = 1'b0;
      end
      default: begin
        onet_nxt = '0;
        omac_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.em != arc_pkg::EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em != arc_pkg::EM_NONE) begin
      kind_r  <= kind_nxt;
      onet_r  <= onet_nxt;
      omac_r  <= omac_nxt;
      oaddr_r <= oaddr_nxt;
      ohdl_r  <= ohdl_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_net   = onet_r;
  assign out_mac   = omac_r;
  assign out_addr  = oaddr_r;
  assign out_hdl   = ohdl_r;
  assign out_last  = olast_r;

  // status to the sequencer
  assign st.action   = act_r;
  assign st.hit      = hit_r;
  assign st.free     = free_r;
  assign st.idx_last = idx_last;
  assign st.pend_loc = pend_loc_r;
  assign st.pend_rem = pend_rem_r;
  assign st.ann_zero = (ann_n_r == '0);
  assign st.can_emit = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/address_resolution_cache.sv =====
// ----------------------------------------------------------------------------
// address_resolution_cache
// Resolution cache from network id and virtual MAC to a care-of address,
// with probe timers, per-entry handle queues and periodic aging.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    tuser action, tdata key/args
//   out_     master     out_tvalid/out_tready  tuser kind, tdata, tlast
//   cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item at a time: a new item is taken only once the previous one has
// registered its closing result. Resolve, announce and remove scan the table
// one entry a cycle; an announce then reads out each queued handle, and a
// tick walks every entry and emits each solicit that falls due. Reset is
// synchronous; the table needs no clearing pass. A stalled result stops the
// sequencer in place.
// ----------------------------------------------------------------------------
`default_nettype none

module address_resolution_cache (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // net_id[31:0] virtual_mac[79:32] care_of_addr[111:80] sender_handle[119:112]
  // probe_local[120] probe_remote[121]
  input  wire logic [127:0] in_tdata,
  // action[2:0]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_net_id[31:0] out_mac[79:32] out_addr[111:80] out_handle[119:112]
  output logic [119:0]      out_tdata,
  // kind[2:0]
  output logic [2:0]        out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  arc_pkg::cmd_t    cmd;
  arc_pkg::status_t st;

  assign cfg_ready = 1'b1;

  arc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  arc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_action (in_tuser),
    .in_net    (in_tdata[31:0]),
    .in_mac    (in_tdata[79:32]),
    .in_addr   (in_tdata[111:80]),
    .in_hdl    (in_tdata[119:112]),
    .in_loc    (in_tdata[120]),
    .in_rem    (in_tdata[121]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_net   (out_tdata[31:0]),
    .out_mac   (out_tdata[79:32]),
    .out_addr  (out_tdata[111:80]),
    .out_hdl   (out_tdata[119:112]),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/core/arc_checker.sv =====
// ----------------------------------------------------------------------------
// arc_checker
// Port-level checks of the address resolution cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [2:0] out_tuser,
  input wire logic       out_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // closing result is done, not found or table full
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == arc_pkg::KIND_DONE ||
                                 out_tuser == arc_pkg::KIND_NOT_FOUND ||
                                 out_tuser == arc_pkg::KIND_FULL))
    else $error("bad kind on closing result");

  // intermediate results are announces or solicits
  a_mid_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tuser == arc_pkg::KIND_ANNOUNCE ||
                                  out_tuser == arc_pkg::KIND_SOL_LOCAL ||
                                  out_tuser == arc_pkg::KIND_SOL_REM))
    else $error("bad kind on intermediate result");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind address_resolution_cache arc_checker u_arc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== tb/sv/address_resolution_cache_test.sv =====
// ----------------------------------------------------------------------------
// address_resolution_cache_test
// Self-checking bench for the address resolution cache. A scoreboard class
// keeps its own copy of the table, queues and timers, predicts every result
// beat of each accepted request and compares them in order. Directed requests
// come first, then random phases under several register settings, the first
// two with random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module address_resolution_cache_test;

  typedef struct {
    logic [arc_pkg::KIND_W-1:0] kind;
    logic [arc_pkg::NET_W-1:0]  net;
    logic [arc_pkg::MAC_W-1:0]  mac;
    logic [arc_pkg::ADDR_W-1:0] addr;
    logic [arc_pkg::HDL_W-1:0]  hdl;
    logic                       last;
  } beat_t;

  // predicts the result beats of the cache and checks the ones that arrive
  class arc_scoreboard;
    logic [arc_pkg::NET_W-1:0]  key_net [arc_pkg::ENTRIES];
    logic [arc_pkg::MAC_W-1:0]  key_mac [arc_pkg::ENTRIES];
    bit                         used    [arc_pkg::ENTRIES];
    logic [arc_pkg::STS_W-1:0]  status  [arc_pkg::ENTRIES];
    logic [arc_pkg::FLG_W-1:0]  flags   [arc_pkg::ENTRIES];
    int                         probes  [arc_pkg::ENTRIES];
    int                         ptimer  [arc_pkg::ENTRIES];
    int                         age     [arc_pkg::ENTRIES];
    logic [arc_pkg::ADDR_W-1:0] addr    [arc_pkg::ENTRIES];
    logic [arc_pkg::HDL_W-1:0]  handles [arc_pkg::ENTRIES][arc_pkg::QUEUE_DEPTH];
    int                         hcount  [arc_pkg::ENTRIES];
    int                         sweep_cnt;
    int                         probe_limit, local_delay, entry_ttl, queue_limit;
    beat_t                      awaited[$];
    int                         errors;

    function new();
      probe_limit = arc_pkg::RST_PROBE_LIMIT;
      local_delay = arc_pkg::RST_LOCAL_DELAY;
      entry_ttl   = arc_pkg::RST_ENTRY_TTL;
      queue_limit = arc_pkg::RST_QUEUE_LIMIT;
      sweep_cnt   = 0;
      errors      = 0;
      for (int i = 0; i < arc_pkg::ENTRIES; i++) begin
        used[i] = 0;
        wipe(i);
      end
    endfunction

    function void wipe(int i);
      used[i]   = 0;
      status[i] = arc_pkg::STS_INCOMPLETE;
      flags[i]  = '0;
      probes[i] = 0;
      ptimer[i] = 0;
      age[i]    = 0;
      addr[i]   = '0;
      hcount[i] = 0;
    endfunction

    function void push(logic [arc_pkg::KIND_W-1:0] k, logic [arc_pkg::NET_W-1:0] n,
                       logic [arc_pkg::MAC_W-1:0] m, logic [arc_pkg::ADDR_W-1:0] a,
                       logic [arc_pkg::HDL_W-1:0] h, logic l);
      beat_t b;
      b.kind = k; b.net = n; b.mac = m; b.addr = a; b.hdl = h; b.last = l;
      awaited.push_back(b);
    endfunction

    function int lookup(logic [arc_pkg::NET_W-1:0] n, logic [arc_pkg::MAC_W-1:0] m);
      for (int i = 0; i < arc_pkg::ENTRIES; i++)
        if (used[i] && key_net[i] == n && key_mac[i] == m) return i;
      return -1;
    endfunction

    function void set_reg(logic [arc_pkg::CFGI_W-1:0] idx, logic [arc_pkg::CFGD_W-1:0] val);
      case (idx)
        arc_pkg::CFG_PROBE_LIMIT: probe_limit = val[3:0];
        arc_pkg::CFG_LOCAL_DELAY: local_delay = val;
        arc_pkg::CFG_ENTRY_TTL:   entry_ttl   = val;
        arc_pkg::CFG_QUEUE_LIMIT: queue_limit = val[3:0];
        default: ;
      endcase
    endfunction

    // newest handles are kept; oldest drop out under the clamped limit
    function void enqueue(int s, logic [arc_pkg::HDL_W-1:0] h);
      int lim, c, drop;
      lim = (queue_limit == 0) ? 1 :
            (queue_limit > arc_pkg::QUEUE_DEPTH) ? arc_pkg::QUEUE_DEPTH : queue_limit;
      c = hcount[s];
      if (c >= lim) begin
        drop = c - lim + 1;
        for (int j = 0; j < c - drop; j++) handles[s][j] = handles[s][j + drop];
        c -= drop;
      end
      handles[s][c] = h;
      hcount[s] = c + 1;
    endfunction

    // probe timer ran out for slot i
    function void expire(int i);
      if (status[i] != arc_pkg::STS_REACHABLE) begin
        if (probes[i] < probe_limit) begin
          if (probes[i] < 15) probes[i]++;
          if (flags[i][arc_pkg::FLAG_LOCAL])
            push(arc_pkg::KIND_SOL_LOCAL, key_net[i], key_mac[i], addr[i], '0, 1'b0);
          if (flags[i][arc_pkg::FLAG_REMOTE])
            push(arc_pkg::KIND_SOL_REM, key_net[i], key_mac[i], addr[i], '0, 1'b0);
        end else begin
          status[i] = arc_pkg::STS_FAILED;
          hcount[i] = 0;
        end
      end
      flags[i] = '0;
    endfunction

    function void note_request(logic [arc_pkg::ACT_W-1:0] act, logic [arc_pkg::NET_W-1:0] n,
                               logic [arc_pkg::MAC_W-1:0] m, logic [arc_pkg::ADDR_W-1:0] a,
                               logic [arc_pkg::HDL_W-1:0] h, logic loc, logic rem);
      int s, ttl;
      ttl = (entry_ttl == 0) ? 1 : entry_ttl;
      s = lookup(n, m);
      case (act)
        arc_pkg::ACT_RESOLVE: begin
          if (s < 0) begin
            for (int i = 0; i < arc_pkg::ENTRIES; i++)
              if (!used[i]) begin
                s = i;
                break;
              end
            if (s < 0) begin
              push(arc_pkg::KIND_FULL, n, m, '0, '0, 1'b1);
              return;
            end
            wipe(s);
            used[s] = 1;
            key_net[s] = n;
            key_mac[s] = m;
          end
          status[s] = arc_pkg::STS_INCOMPLETE;
          flags[s][arc_pkg::FLAG_LOCAL]  |= loc;
          flags[s][arc_pkg::FLAG_REMOTE] |= rem;
          enqueue(s, h);
          if (!flags[s][arc_pkg::FLAG_PROBING]) begin
            flags[s][arc_pkg::FLAG_PROBING] = 1'b1;
            probes[s] = 1;
            ptimer[s] = (local_delay == 0) ? 1 : local_delay;
          end
          push(arc_pkg::KIND_DONE, n, m, addr[s], '0, 1'b1);
        end
        arc_pkg::ACT_ANNOUNCE: begin
          if (s < 0) begin
            push(arc_pkg::KIND_NOT_FOUND, n, m, '0, '0, 1'b1);
            return;
          end
          addr[s] = a;
          age[s] = 0;
          status[s] = arc_pkg::STS_REACHABLE;
          for (int c = hcount[s] - 1; c >= 0; c--)
            push(arc_pkg::KIND_ANNOUNCE, n, m, a, handles[s][c], 1'b0);
          hcount[s] = 0;
          push(arc_pkg::KIND_DONE, n, m, a, '0, 1'b1);
        end
        arc_pkg::ACT_REMOVE: begin
          if (s < 0) begin
            push(arc_pkg::KIND_NOT_FOUND, n, m, '0, '0, 1'b1);
            return;
          end
          push(arc_pkg::KIND_DONE, n, m, addr[s], '0, 1'b1);
          wipe(s);
        end
        arc_pkg::ACT_TICK: begin
          for (int i = 0; i < arc_pkg::ENTRIES; i++) begin
            if (!used[i]) continue;
            if (age[i] < 16'hFFFF) age[i]++;
            if (ptimer[i] != 0) begin
              ptimer[i]--;
              if (ptimer[i] == 0) expire(i);
            end
          end
          sweep_cnt++;
          if (sweep_cnt >= ttl) begin
            sweep_cnt = 0;
            for (int i = 0; i < arc_pkg::ENTRIES; i++)
              if (used[i] && age[i] > ttl) status[i] = arc_pkg::STS_INCOMPLETE;
          end
          push(arc_pkg::KIND_DONE, '0, '0, '0, '0, 1'b1);
        end
        arc_pkg::ACT_SWEEP: begin
          for (int i = 0; i < arc_pkg::ENTRIES; i++)
            if (used[i]) status[i] = arc_pkg::STS_INCOMPLETE;
          push(arc_pkg::KIND_DONE, '0, '0, '0, '0, 1'b1);
        end
        default: push(arc_pkg::KIND_DONE, '0, '0, '0, '0, 1'b1);
      endcase
    endfunction

    function void check_beat(logic [arc_pkg::KIND_W-1:0] kind, logic [119:0] data, logic last);
      beat_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result beat kind=%0d", kind);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d got %0d", e.kind, kind); errors++;
      end
      if (data[31:0] !== e.net) begin
        $error("out_net_id: expected %h got %h", e.net, data[31:0]); errors++;
      end
      if (data[79:32] !== e.mac) begin
        $error("out_mac: expected %h got %h", e.mac, data[79:32]); errors++;
      end
      if (data[111:80] !== e.addr) begin
        $error("out_addr: expected %h got %h", e.addr, data[111:80]); errors++;
      end
      if (data[119:112] !== e.hdl) begin
        $error("out_handle: expected %h got %h", e.hdl, data[119:112]); errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d got %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  arc_scoreboard             sb = new();
  int                        send_idle = 23;
  int                        recv_idle = 54;
  int                        quiet_cycles = 0;
  logic [arc_pkg::NET_W-1:0] pool_net [20];
  logic [arc_pkg::MAC_W-1:0] pool_mac [20];

  address_resolution_cache u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (in_tvalid && in_tready)
      sb.note_request(in_tuser, in_tdata[31:0], in_tdata[79:32], in_tdata[111:80],
                      in_tdata[119:112], in_tdata[120], in_tdata[121]);
    if (out_tvalid && out_tready) sb.check_beat(out_tuser, out_tdata, out_tlast);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_req(logic [arc_pkg::ACT_W-1:0] act, logic [arc_pkg::NET_W-1:0] n,
                          logic [arc_pkg::MAC_W-1:0] m, logic [arc_pkg::ADDR_W-1:0] a,
                          logic [arc_pkg::HDL_W-1:0] h, logic loc, logic rem);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {6'b0, rem, loc, h, a, m, n};
    do @(posedge clk); while (!in_tready);
  endtask

  // random request on a pooled key, sometimes on a fresh key
  task automatic send_random();
    int r, k;
    logic [arc_pkg::ACT_W-1:0] act;
    r = $urandom_range(99);
    k = $urandom_range(19);
    if (r < 35) act = arc_pkg::ACT_RESOLVE;
    else if (r < 55) act = arc_pkg::ACT_ANNOUNCE;
    else if (r < 85) act = arc_pkg::ACT_TICK;
    else if (r < 92) act = arc_pkg::ACT_REMOVE;
    else if (r < 96) act = arc_pkg::ACT_SWEEP;
    else act = arc_pkg::ACT_W'($urandom_range(7, 5));
    if ($urandom_range(49) == 0)
      send_req(act, $urandom, arc_pkg::MAC_W'({$urandom, $urandom}), $urandom,
               arc_pkg::HDL_W'($urandom), 1'($urandom), 1'($urandom));
    else
      send_req(act, pool_net[k], pool_mac[k], $urandom, arc_pkg::HDL_W'($urandom),
               1'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [arc_pkg::CFGI_W-1:0] idx, logic [arc_pkg::CFGD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(int pl, int ld, int ttl, int ql);
    write_reg(arc_pkg::CFG_PROBE_LIMIT, arc_pkg::CFGD_W'(pl));
    write_reg(arc_pkg::CFG_LOCAL_DELAY, arc_pkg::CFGD_W'(ld));
    write_reg(arc_pkg::CFG_ENTRY_TTL, arc_pkg::CFGD_W'(ttl));
    write_reg(arc_pkg::CFG_QUEUE_LIMIT, arc_pkg::CFGD_W'(ql));
  endtask

  task automatic random_phase(int count, int sidle, int ridle);
    send_idle = sidle;
    recv_idle = ridle;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      send_random();
    end
    wait_drained();
  endtask

  initial begin
    pool_net[0] = '1; pool_mac[0] = '1;
    pool_net[1] = '0; pool_mac[1] = '0;
    for (int i = 2; i < 20; i++) begin
      pool_net[i] = $urandom;
      pool_mac[i] = arc_pkg::MAC_W'({$urandom, $urandom});
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: short timers so expiry and solicits show up quickly
    set_all(2, 2, 3, 3);
    send_req(arc_pkg::ACT_RESOLVE, pool_net[0], pool_mac[0], '0, 8'hFF, 1'b1, 1'b1);
    for (int h = 1; h <= 4; h++)
      send_req(arc_pkg::ACT_RESOLVE, pool_net[0], pool_mac[0], '0, arc_pkg::HDL_W'(h),
               1'b0, 1'b0);
    send_req(arc_pkg::ACT_ANNOUNCE, pool_net[0], pool_mac[0], 32'hFFFF_FFFF, '0, 1'b0, 1'b0);
    send_req(arc_pkg::ACT_ANNOUNCE, pool_net[1], pool_mac[1], 32'h1234_5678, '0, 1'b0, 1'b0);
    send_req(arc_pkg::ACT_REMOVE, pool_net[1], pool_mac[1], '0, '0, 1'b0, 1'b0);
    send_req(arc_pkg::ACT_RESOLVE, pool_net[1], pool_mac[1], '0, 8'h00, 1'b1, 1'b0);
    send_req(arc_pkg::ACT_RESOLVE, pool_net[2], pool_mac[2], '0, 8'h5A, 1'b0, 1'b1);
    repeat (6) send_req(arc_pkg::ACT_TICK, '0, '0, '0, '0, 1'b0, 1'b0);
    send_req(arc_pkg::ACT_SWEEP, '0, '0, '0, '0, 1'b0, 1'b0);
    send_req(3'd5, '1, '1, '1, '1, 1'b1, 1'b1);
    send_req(3'd6, '0, '0, '0, '0, 1'b0, 1'b0);
    send_req(3'd7, '0, '0, '0, '0, 1'b0, 1'b0);
    send_req(arc_pkg::ACT_REMOVE, pool_net[0], pool_mac[0], '0, '0, 1'b0, 1'b0);
    wait_drained();

    // random phases, registers changed only while the block is empty
    set_all(15, 0, 0, 15);
    random_phase(140, 23, 54);
    set_all(0, 65535, 65535, 0);
    random_phase(120, 54, 23);
    set_all(4, 3, 5, 1);
    random_phase(140, 0, 0);

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/arc_pkg.sv
rtl/core/arc_ctrl.sv
rtl/core/arc_dp.sv
rtl/core/address_resolution_cache.sv
rtl/core/arc_checker.sv
tb/sv/address_resolution_cache_test.sv
